FILE: sv/iocl_pkg.sv
// ============================================================================
// iocl_pkg
// Shared types and constants for the interval overlap cluster table.
// ============================================================================
package iocl_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int NODE_ID_BITS = 20;
    localparam int SLOT_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = 6;
    localparam int MASK_BITS    = 32;
    localparam int PROD_BITS    = 2 * NODE_ID_BITS;

    typedef logic [NODE_ID_BITS-1:0] node_t;
    typedef logic [SLOT_BITS-1:0]    slot_t;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [0:0] REG_KBEST = 1'b0;
    localparam logic [0:0] REG_BEST  = 1'b1;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;      // capture the accepted beat
        logic scan;      // process slot at scan index
        logic scan_rst;  // restart scan index and pass flags
        logic commit;    // finish the item: table update for insert/remove, write result
        logic pick;      // absorb the k-best winner
        logic clear_out; // mask the result valid output
    } iocl_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       kbest;
        logic       scan_last;
        logic       grew;
        logic       have_best;
        logic       k_done;
        logic       out_busy;
    } iocl_sts_t;

endpackage

FILE: sv/iocl_if.sv
// ============================================================================
// iocl_in_if / iocl_out_if
// Valid/ready channels for request and result beats.
// ============================================================================
interface iocl_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [iocl_pkg::NODE_ID_BITS-1:0] node_a;
    logic [iocl_pkg::NODE_ID_BITS-1:0] node_b;
    modport source (output valid, opcode, node_a, node_b, input ready);
    modport sink   (input valid, opcode, node_a, node_b, output ready);
endinterface

interface iocl_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [iocl_pkg::NODE_ID_BITS-1:0] extent_low;
    logic [iocl_pkg::NODE_ID_BITS-1:0] extent_high;
    logic [iocl_pkg::CNT_BITS-1:0]  member_count;
    logic [iocl_pkg::MASK_BITS-1:0] member_mask;
    modport source (output valid, status, extent_low, extent_high, member_count,
                    member_mask, input ready);
    modport sink   (input valid, status, extent_low, extent_high, member_count,
                    member_mask, output ready);
endinterface

FILE: sv/interval_overlap_cluster_table.sv
// Insert, remove and unused op make one scan pass over the table; a closure query
// repeats passes while a pass grew the extent; a k-best query alternates a scan pass
// and a pick, absorbing at most best_count entries.
// One item at a time: the next beat is taken after the result is written; a result
// left waiting holds the finished item in the controller, not the input.
// Reset clears slot valid bits, config registers and the result valid flag.
// ============================================================================
// interval_overlap_cluster_table
// Top level: controller and datapath of the interval cluster table.
// ============================================================================
module interval_overlap_cluster_table
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data,
    iocl_in_if.sink    req,
    iocl_out_if.source rsp
);
    import iocl_pkg::*;

    iocl_cmd_t cmd;
    iocl_sts_t sts;

    iocl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iocl_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (req.opcode),
        .in_node_a (req.node_a),
        .in_node_b (req.node_b),
        .cmd       (cmd),
        .sts       (sts),
        .res       (rsp)
    );

endmodule

FILE: sv/iocl_ctrl.sv
// ============================================================================
// iocl_ctrl
// Sequencer: steps slot scans for insert, remove, closure and k-best passes.
// ============================================================================
module iocl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iocl_pkg::iocl_sts_t sts,
    output iocl_pkg::iocl_cmd_t cmd
);
    import iocl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PICK = 5'b00100,
        S_DONE = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_rst = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    if (sts.op == OP_QUERY && sts.kbest)
                        state_next = S_PICK;
                    else if (sts.op == OP_QUERY && sts.grew)
                        cmd.scan_rst = 1'b1;
                    else
                        state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                if (sts.have_best && !sts.k_done)
                begin
                    cmd.pick     = 1'b1;
                    cmd.scan_rst = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the finished item until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/iocl_dpath.sv
// ============================================================================
// iocl_dpath
// Slot table, scan logic, IoU compare and result register.
// ============================================================================
module iocl_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [iocl_pkg::CNT_BITS-1:0] cfg_data,
    input  logic [1:0]                    in_opcode,
    input  logic [iocl_pkg::NODE_ID_BITS-1:0] in_node_a,
    input  logic [iocl_pkg::NODE_ID_BITS-1:0] in_node_b,
    input  iocl_pkg::iocl_cmd_t           cmd,
    output iocl_pkg::iocl_sts_t           sts,
    iocl_out_if.source                    res
);
    import iocl_pkg::*;

    // Configuration
    logic                kbest_reg;
    logic [CNT_BITS-1:0] best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbest_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KBEST)
                kbest_reg <= cfg_data[0];
            else
                best_reg <= cfg_data;
        end
    end

    // Table storage
    logic [TABLE_DEPTH-1:0] valid_reg;
    node_t                  lo_mem [TABLE_DEPTH];
    node_t                  hi_mem [TABLE_DEPTH];

    // Request and working registers
    logic [1:0]             op_reg;
    logic                   mode_k_reg;
    node_t                  q_lo_reg, q_hi_reg, ext_lo_reg, ext_hi_reg;
    slot_t                  idx_reg;
    logic [TABLE_DEPTH-1:0] member_reg;
    logic                   grew_reg, hit_reg, free_found_reg;
    slot_t                  hit_slot_reg, free_slot_reg;
    logic                   best_v_reg;
    slot_t                  best_slot_reg;
    node_t                  best_i_reg, best_u_reg;
    logic [CNT_BITS-1:0]    picked_reg;

    // Current slot
    node_t s_lo, s_hi, ovl_lo, ovl_hi, q_ovl_lo, q_ovl_hi, inter, uni;
    logic  s_valid, ext_ovl, q_ovl, eq_hit, better;
    logic [PROD_BITS-1:0] lhs, rhs;

    always_comb
    begin
        s_lo     = lo_mem[idx_reg];
        s_hi     = hi_mem[idx_reg];
        s_valid  = valid_reg[idx_reg];
        ovl_lo   = (ext_lo_reg > s_lo) ? ext_lo_reg : s_lo;
        ovl_hi   = (ext_hi_reg < s_hi) ? ext_hi_reg : s_hi;
        ext_ovl  = ovl_hi > ovl_lo;
        q_ovl_lo = (q_lo_reg > s_lo) ? q_lo_reg : s_lo;
        q_ovl_hi = (q_hi_reg < s_hi) ? q_hi_reg : s_hi;
        q_ovl    = q_ovl_hi > q_ovl_lo;
        inter    = q_ovl_hi - q_ovl_lo;
        uni      = ((q_hi_reg > s_hi) ? q_hi_reg : s_hi)
                 - ((q_lo_reg < s_lo) ? q_lo_reg : s_lo);
        eq_hit   = s_valid && (s_lo == q_lo_reg) && (s_hi == q_hi_reg);
        lhs      = PROD_BITS'(inter) * PROD_BITS'(best_u_reg);
        rhs      = PROD_BITS'(best_i_reg) * PROD_BITS'(uni);
        better   = !best_v_reg || (lhs > rhs);
    end

    // Normalize endpoints of the incoming beat
    node_t n_lo, n_hi;
    assign n_lo = (in_node_a < in_node_b) ? in_node_a : in_node_b;
    assign n_hi = (in_node_a < in_node_b) ? in_node_b : in_node_a;

    // Table writes
    always_ff @(posedge clk)
    begin
        if (cmd.commit && op_reg == OP_INSERT && !hit_reg && free_found_reg)
        begin
            lo_mem[free_slot_reg] <= q_lo_reg;
            hi_mem[free_slot_reg] <= q_hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.commit)
        begin
            if (op_reg == OP_INSERT && !hit_reg && free_found_reg)
                valid_reg[free_slot_reg] <= 1'b1;
            else if (op_reg == OP_REMOVE && hit_reg)
                valid_reg[hit_slot_reg] <= 1'b0;
        end
    end

    // Scan engine
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_opcode;
            mode_k_reg <= kbest_reg && (best_reg != '0);
            q_lo_reg   <= n_lo;
            q_hi_reg   <= n_hi;
            ext_lo_reg <= n_lo;
            ext_hi_reg <= n_hi;
            member_reg <= '0;
            hit_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            picked_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (op_reg == OP_QUERY && !mode_k_reg)
            begin
                if (s_valid && !member_reg[idx_reg] && ext_ovl)
                begin
                    member_reg[idx_reg] <= 1'b1;
                    // a new pass clears the flag below
                    if (!cmd.scan_rst)
                        grew_reg <= 1'b1;
                    if (s_lo < ext_lo_reg) ext_lo_reg <= s_lo;
                    if (s_hi > ext_hi_reg) ext_hi_reg <= s_hi;
                end
            end
            else if (op_reg == OP_QUERY)
            begin
                if (s_valid && !member_reg[idx_reg] && q_ovl && better)
                begin
                    best_v_reg    <= 1'b1;
                    best_slot_reg <= idx_reg;
                    best_i_reg    <= inter;
                    best_u_reg    <= uni;
                end
            end
            else
            begin
                if (eq_hit && !hit_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= idx_reg;
                end
                if (!s_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= idx_reg;
                end
            end
        end
        else if (cmd.pick)
        begin
            member_reg[best_slot_reg] <= 1'b1;
            picked_reg <= picked_reg + CNT_BITS'(1);
            if (lo_mem[best_slot_reg] < ext_lo_reg) ext_lo_reg <= lo_mem[best_slot_reg];
            if (hi_mem[best_slot_reg] > ext_hi_reg) ext_hi_reg <= hi_mem[best_slot_reg];
        end
        // scan index and pass flags
        if (cmd.load || cmd.scan_rst)
        begin
            idx_reg    <= '0;
            grew_reg   <= 1'b0;
            best_v_reg <= 1'b0;
        end
        else if (cmd.scan)
            idx_reg <= idx_reg + slot_t'(1);
    end

    assign sts.op        = op_reg;
    assign sts.kbest     = mode_k_reg;
    assign sts.scan_last = (idx_reg == slot_t'(TABLE_DEPTH - 1));
    assign sts.grew      = grew_reg || (s_valid && !member_reg[idx_reg] && ext_ovl);
    assign sts.have_best = best_v_reg;
    assign sts.k_done    = (picked_reg == best_reg);
    assign sts.out_busy  = res.valid;

    // Member count
    logic [CNT_BITS-1:0] cnt;
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            cnt = cnt + CNT_BITS'(member_reg[i]);
    end

    // Result register
    logic ovalid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.commit)
            ovalid_reg <= 1'b1;
        else if (res.ready)
            ovalid_reg <= 1'b0;
    end

    logic [1:0]           st_reg;
    node_t                el_reg, eh_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [MASK_BITS-1:0] mask_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            st_reg   <= ST_DONE;
            el_reg   <= '0;
            eh_reg   <= '0;
            cnt_reg  <= '0;
            mask_reg <= '0;
            if (op_reg == OP_INSERT)
                st_reg <= hit_reg ? ST_MISS : (free_found_reg ? ST_DONE : ST_FULL);
            else if (op_reg == OP_REMOVE)
                st_reg <= hit_reg ? ST_DONE : ST_MISS;
            else if (op_reg == OP_QUERY)
            begin
                el_reg   <= ext_lo_reg;
                eh_reg   <= ext_hi_reg;
                cnt_reg  <= cnt;
                mask_reg <= MASK_BITS'(member_reg);
            end
        end
    end

    assign res.valid        = ovalid_reg && !cmd.clear_out;
    assign res.status       = st_reg;
    assign res.extent_low   = el_reg;
    assign res.extent_high  = eh_reg;
    assign res.member_count = cnt_reg;
    assign res.member_mask  = mask_reg;

endmodule
